// File: rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// types and constants shared by the k-way sorted merge block
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned DefaultLists     = 16;
  localparam int unsigned DefaultListDepth = 64;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned SelW    = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_CLEAR3 = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_TAKEN    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [SelW-1:0]          list_sel;
    logic signed [ValueW-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_out;
    logic [SelW-1:0]          list_out;
    logic [StatusW-1:0]       status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_FINISH,
    S_CLEAR,
    S_OUT
  } state_e;

endpackage

// File: rtl/kwm_store.sv
// ----------------------------------------------------------------------------
// kwm_store
// element memory, one write and one registered read port
// ----------------------------------------------------------------------------
module kwm_store import kwm_pkg::*; #(
  parameter int unsigned Depth = DefaultLists * DefaultListDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic signed [ValueW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic signed [ValueW-1:0] rdata_o
);

  logic signed [ValueW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/kwm_ptrs.sv
// ----------------------------------------------------------------------------
// kwm_ptrs
// per-list read and write pointer memory, registered read
// ----------------------------------------------------------------------------
module kwm_ptrs import kwm_pkg::*; #(
  parameter int unsigned Lists = DefaultLists,
  parameter int unsigned PtrW  = 7,
  parameter int unsigned LW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [LW-1:0]     waddr_i,
  input  logic [2*PtrW-1:0] wdata_i,
  input  logic [LW-1:0]     raddr_i,
  output logic [2*PtrW-1:0] rdata_o
);

  logic [2*PtrW-1:0] mem [Lists];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/k_way_sorted_merge_top.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// k-way merge of sorted lists held in one element memory
// ----------------------------------------------------------------------------
// Holds Lists lists of signed 32-bit words, ListDepth each; the lists are
// meant to ascend, but appends are not checked for order. Every input word
// gives one output word. An append or a full drop passes through S_APPEND
// and S_OUT. A take runs S_SCAN and S_FINISH: the head scan issues one
// list's pointer read a cycle, the head read follows in the next cycle, and
// the scan ends once both stages have drained. After reset the block runs a
// clearing pass over every list's pointers before it accepts input; a clear
// command repeats that pass. The output is registered; the next word is
// taken once the result has left.
module k_way_sorted_merge_top import kwm_pkg::*; #(
  parameter int unsigned Lists     = DefaultLists,
  parameter int unsigned ListDepth = DefaultListDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned LW    = (Lists > 1) ? $clog2(Lists) : 1;
  localparam int unsigned DW    = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int unsigned PtrW  = $clog2(ListDepth + 1);
  localparam int unsigned AddrW = LW + DW;
  localparam int unsigned CntW  = LW + 1;

  state_e state_q, state_d;
  in_word_t in_q, in_d;
  out_word_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic found_q, found_d;
  logic [LW-1:0] best_q, best_d;
  logic signed [ValueW-1:0] bestv_q, bestv_d;
  logic [PtrW-1:0] bestrp_q, bestrp_d, bestwp_q, bestwp_d;
  // pipeline of the scan: stage a pointer read, stage b element read
  logic va_q, va_d, vb_q, vb_d;
  logic [LW-1:0] la_q, la_d, lb_q, lb_d;
  logic [PtrW-1:0] rpb_q, rpb_d, wpb_q, wpb_d;

  logic p_we, s_we;
  logic [LW-1:0] p_waddr, p_raddr;
  logic [2*PtrW-1:0] p_wdata, p_rdata;
  logic [AddrW-1:0] s_waddr, s_raddr;
  logic signed [ValueW-1:0] s_rdata;
  logic [PtrW-1:0] rp_a, wp_a;

  kwm_ptrs #(.Lists(Lists), .PtrW(PtrW), .LW(LW)) u_ptrs (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  kwm_store #(.Depth(Lists * (2 ** DW)), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(in_q.value_in),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign rp_a = p_rdata[2*PtrW-1:PtrW];
  assign wp_a = p_rdata[PtrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      in_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_q        <= in_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      va_q        <= va_d;
      vb_q        <= vb_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    best_q   <= best_d;
    bestv_q  <= bestv_d;
    bestrp_q <= bestrp_d;
    bestwp_q <= bestwp_d;
    la_q     <= la_d;
    lb_q     <= lb_d;
    rpb_q    <= rpb_d;
    wpb_q    <= wpb_d;
  end

  logic sel_ok;
  assign sel_ok = ({{(32-SelW){1'b0}}, in_q.list_sel} < Lists);

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    best_d      = best_q;
    bestv_d     = bestv_q;
    bestrp_d    = bestrp_q;
    bestwp_d    = bestwp_q;
    va_d        = 1'b0;
    vb_d        = 1'b0;
    la_d        = la_q;
    lb_d        = la_q;
    rpb_d       = rp_a;
    wpb_d       = wp_a;
    in_ready_o  = 1'b0;
    p_we        = 1'b0;
    p_waddr     = LW'(in_q.list_sel);
    p_wdata     = '0;
    p_raddr     = LW'(in_q.list_sel);
    s_we        = 1'b0;
    s_waddr     = {LW'(in_q.list_sel), wp_a[DW-1:0]};
    s_raddr     = {la_q, rp_a[DW-1:0]};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q;
        if (in_valid_i && !out_valid_q) begin
          in_d = in_data_i;
          unique case (cmd_e'(in_data_i.cmd))
            CMD_APPEND: state_d = S_APPEND;
            CMD_TAKE: begin
              state_d = S_SCAN;
              cnt_d   = '0;
              found_d = 1'b0;
            end
            CMD_CLEAR, CMD_CLEAR3: begin
              state_d = S_CLEAR;
              cnt_d   = '0;
            end
            default: state_d = S_CLEAR;
          endcase
          p_raddr = LW'(in_data_i.list_sel);
        end
      end
      S_APPEND: begin
        out_d.value_out = '0;
        out_d.list_out  = in_q.list_sel;
        if (sel_ok && ({{(32-PtrW){1'b0}}, wp_a} < ListDepth)) begin
          s_we    = 1'b1;
          p_we    = 1'b1;
          p_wdata = {rp_a, wp_a + PtrW'(1)};
          out_d.status = ST_APPENDED;
        end else begin
          out_d.status = ST_FULL;
        end
        state_d = S_OUT;
      end
      S_SCAN: begin
        // issue pointer reads for each list, then element reads, pipelined
        if (cnt_q < CntW'(Lists)) begin
          p_raddr = cnt_q[LW-1:0];
          va_d    = 1'b1;
          la_d    = cnt_q[LW-1:0];
          cnt_d   = cnt_q + CntW'(1);
        end
        vb_d = va_q && (rp_a < wp_a);
        if (vb_q && (!found_q || s_rdata < bestv_q)) begin
          found_d  = 1'b1;
          best_d   = lb_q;
          bestv_d  = s_rdata;
          bestrp_d = rpb_q;
          bestwp_d = wpb_q;
        end
        if (cnt_q == CntW'(Lists) && !va_q && !vb_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (found_q) begin
          p_we    = 1'b1;
          p_waddr = best_q;
          if (bestrp_q + PtrW'(1) >= bestwp_q) begin
            p_wdata = '0;
          end else begin
            p_wdata = {bestrp_q + PtrW'(1), bestwp_q};
          end
          out_d.value_out = bestv_q;
          out_d.list_out  = SelW'(best_q);
          out_d.status    = ST_TAKEN;
        end else begin
          out_d.value_out = '0;
          out_d.list_out  = '0;
          out_d.status    = ST_EMPTY;
        end
        state_d = S_OUT;
      end
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = cnt_q[LW-1:0];
        p_wdata = '0;
        if (cnt_q == CntW'(Lists - 1)) begin
          cnt_d = '0;
          if (in_q.cmd != CMD_APPEND && in_q.cmd != CMD_TAKE) begin
            out_d.value_out = '0;
            out_d.list_out  = '0;
            out_d.status    = ST_CLEARED;
            state_d         = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_OUT: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  property p_out_free;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_OUT |-> !out_valid_q);
  endproperty
  assert property (p_out_free) else $error("result overwritten");

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (in_ready_o |-> state_q == S_IDLE);
  endproperty
  assert property (p_no_accept_busy) else $error("input taken while busy");

  property p_out_follows;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_OUT |=> out_valid_q);
  endproperty
  assert property (p_out_follows) else $error("result lost");

  property p_take_status;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_FINISH && !found_q |=> out_q.status == ST_EMPTY);
  endproperty
  assert property (p_take_status) else $error("empty take misreported");

endmodule

// File: tb/tb_k_way_sorted_merge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_way_sorted_merge_top
// self-checking bench for the k-way sorted merge block
// ----------------------------------------------------------------------------
// Keeps its own copy of every list with read and write pointers, predicts
// the result word of each accepted input word and compares results in order.
// Stimulus: directed corner words, then random load and drain phases with
// bursty input, a stalling output, one long output hold-off and full
// drain pauses.
// ----------------------------------------------------------------------------
module tb_k_way_sorted_merge_top;
  import kwm_pkg::*;

  localparam int unsigned NumLists = DefaultLists;
  localparam int unsigned Depth    = DefaultListDepth;

  class merge_scoreboard;
    logic signed [ValueW-1:0] lists_q [NumLists][Depth];
    int unsigned rd_ptr [NumLists];
    int unsigned wr_ptr [NumLists];
    out_word_t   pending_q [$];
    int          mismatches;

    function void clear_lists();
      foreach (rd_ptr[l]) begin
        rd_ptr[l] = 0;
        wr_ptr[l] = 0;
      end
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      bit        found;
      int        best;
      r = '0;
      found = 0;
      best = 0;
      case (w.cmd)
        CMD_APPEND: begin
          r.list_out = w.list_sel;
          if (w.list_sel < NumLists && wr_ptr[w.list_sel] < Depth) begin
            lists_q[w.list_sel][wr_ptr[w.list_sel]] = w.value_in;
            wr_ptr[w.list_sel]++;
            r.status = ST_APPENDED;
          end else begin
            r.status = ST_FULL;
          end
        end
        CMD_TAKE: begin
          for (int l = 0; l < NumLists; l++) begin
            if (rd_ptr[l] < wr_ptr[l] &&
                (!found || lists_q[l][rd_ptr[l]] < lists_q[best][rd_ptr[best]])) begin
              found = 1;
              best = l;
            end
          end
          if (found) begin
            r.value_out = lists_q[best][rd_ptr[best]];
            r.list_out = best[SelW-1:0];
            r.status = ST_TAKEN;
            rd_ptr[best]++;
            if (rd_ptr[best] >= wr_ptr[best]) begin
              rd_ptr[best] = 0;
              wr_ptr[best] = 0;
            end
          end else begin
            r.status = ST_EMPTY;
          end
        end
        default: begin
          clear_lists();
          r.status = ST_CLEARED;
        end
      endcase
      pending_q.insert(pending_q.size(), r);
    endfunction

    task check_result(out_word_t got);
      out_word_t exp;
      if (pending_q.size() == 0) begin
        report("unexpected result word", 0, got);
        return;
      end
      exp = pending_q.pop_front();
      if (got.value_out !== exp.value_out) report("value_out", exp.value_out, got.value_out);
      if (got.list_out !== exp.list_out) report("list_out", exp.list_out, got.list_out);
      if (got.status !== exp.status) report("status", exp.status, got.status);
    endtask

    task report(string what, logic [63:0] exp, logic [63:0] got);
      mismatches++;
      $display("mismatch %s: expected %0h got %0h", what, exp, got);
    endtask
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 0;
  out_word_t out_data_o;

  merge_scoreboard merge_sb = new();
  bit hold_off_req = 0;
  bit hold_done = 0;
  int sent_words = 0;

  k_way_sorted_merge_top u_top (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) merge_sb.note_word(in_data_i);
    if (out_valid_o && out_ready_i) merge_sb.check_result(out_data_o);
  end

  // output stall pattern plus one long hold-off
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_off_req = 0;
      end
      mode = (sent_words / 100) % 3;
      if (mode == 0) begin
        out_ready_i <= 1'b1;
      end else if (mode == 1) begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready_i <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  task automatic send_word(logic [CmdW-1:0] c, logic [SelW-1:0] s, logic [ValueW-1:0] v);
    in_valid_i <= 1;
    in_data_i <= '{cmd: c, list_sel: s, value_in: v};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_words++;
  endtask

  task automatic gap_maybe(ref int burst);
    if (burst > 0) begin
      burst--;
      return;
    end
    in_valid_i <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    burst = $urandom_range(0, 12);
  endtask

  task automatic drain_all();
    in_valid_i <= 0;
    while (merge_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst;
    int vals [NumLists];
    burst = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed corners
    send_word(CMD_TAKE, 4'd0, '0);
    send_word(CMD_APPEND, 4'd15, 32'h8000_0000);
    send_word(CMD_APPEND, 4'd0, 32'h8000_0000);
    send_word(CMD_APPEND, 4'd0, 32'h7fff_ffff);
    send_word(CMD_APPEND, 4'd3, 32'hffff_ffff);
    send_word(CMD_APPEND, 4'd3, 32'h0000_0005);
    send_word(CMD_APPEND, 4'd7, 32'h0000_0002);
    send_word(CMD_APPEND, 4'd7, 32'h0000_0001);
    for (int i = 0; i < 8; i++) send_word(CMD_TAKE, 4'($urandom), $urandom);
    send_word(CMD_APPEND, 4'd9, 32'h1234_5678);
    send_word(CMD_CLEAR, 4'd9, $urandom);
    send_word(CMD_TAKE, 4'd0, '0);
    send_word(CMD_APPEND, 4'd1, 32'h0);
    send_word(CMD_CLEAR3, 4'hf, 32'hffff_ffff);
    send_word(CMD_TAKE, 4'd0, '0);
    // fill one list past full
    for (int i = 0; i <= Depth; i++) send_word(CMD_APPEND, 4'd5, i);
    drain_all();
    send_word(CMD_CLEAR, 4'd0, '0);

    // random load and drain phases with mostly ascending content
    while (sent_words < 640) begin
      int n;
      if (sent_words > 300 && !hold_done) begin
        hold_off_req = 1;
        hold_done = 1;
      end
      foreach (vals[l]) vals[l] = $urandom_range(0, 50) - 25;
      n = $urandom_range(5, 60);
      for (int i = 0; i < n; i++) begin
        int l;
        l = $urandom_range(0, NumLists - 1);
        if ($urandom_range(0, 9) == 0) begin
          send_word(CMD_APPEND, 4'(l), rand_value());
        end else begin
          vals[l] += $urandom_range(0, 40);
          send_word(CMD_APPEND, 4'(l), vals[l]);
        end
        gap_maybe(burst);
      end
      n = $urandom_range(5, 70);
      for (int i = 0; i < n; i++) begin
        send_word($urandom_range(0, 19) == 0 ? CMD_APPEND : CMD_TAKE,
                  4'($urandom), rand_value());
        gap_maybe(burst);
      end
      if ($urandom_range(0, 7) == 0) send_word($urandom_range(0, 1) ? CMD_CLEAR : CMD_CLEAR3,
                                               4'($urandom), $urandom);
      if (sent_words > 500 && sent_words < 600) drain_all();
    end

    drain_all();
    repeat (200) @(posedge clk_i);
    if (merge_sb.mismatches == 0 && merge_sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
